[rtl/sorted_priority_task_queue_assert.svh]
// ----------------------------------------------------------------------------
// sorted_priority_task_queue_assert.svh
// Assertion macros used by the queue checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_TASK_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_TASK_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPTQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sptq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPTQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sptq assertion failed");

`endif

[rtl/sptq_pkg.sv]
// ----------------------------------------------------------------------------
// sptq_pkg
// Types, constants and helpers of the sorted priority task queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sptq_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int TAG_BITS    = 16;

    localparam int PRIO_W      = 7;
    localparam int PRIO_MAX    = 100;
    localparam int REQ_W       = 16;
    localparam int IN_TAG_W    = 16;
    localparam int OUT_TAG_W   = 16;
    localparam int POS_W       = 5;
    localparam int PEND_W      = 6;

    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int GRP_SIZE    = 8;
    localparam int NUM_GRP     = (QUEUE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_CNT_W   = $clog2(GRP_SIZE + 1);

    localparam logic signed [REQ_W-1:0] PRIO_MAX_REQ = REQ_W'(PRIO_MAX);

    localparam logic ACT_SCHEDULE = 1'b0;
    localparam logic ACT_EXECUTE  = 1'b1;

    typedef enum logic [1:0] {
        KIND_SCHED = 2'd0,
        KIND_TASK  = 2'd1,
        KIND_DONE  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NO_NAME = 2'd1,
        STS_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic                    action;
        logic                    name_present;
        logic [IN_TAG_W-1:0]     task_tag;
        logic signed [REQ_W-1:0] priority_req;
    } request_t;

    typedef struct packed {
        kind_t                kind;
        status_t              status;
        logic [POS_W-1:0]     position;
        logic [OUT_TAG_W-1:0] out_tag;
        logic [PRIO_W-1:0]    out_priority;
        logic                 drain_ok;
        logic [PEND_W-1:0]    pending_count;
        logic                 last;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic insert;
        logic drain_step;
        logic drain_end;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cnt_zero;
    } dp_status_t;

    function automatic logic [PRIO_W-1:0] clamp_prio(input logic signed [REQ_W-1:0] req);
        logic [PRIO_W-1:0] p;
        if (req < 0)
        begin
            p = '0;
        end
        else if (req > PRIO_MAX_REQ)
        begin
            p = PRIO_W'(PRIO_MAX);
        end
        else
        begin
            p = req[PRIO_W-1:0];
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/sptq_ctrl.sv]
// ----------------------------------------------------------------------------
// sptq_ctrl
// Sequencer of the queue: schedule compare/insert and drain walk.
// ----------------------------------------------------------------------------
`default_nettype none

module sptq_ctrl
    import sptq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic       action,
    input  wire dp_status_t dp_status,
    output ctrl_cmd_t       cmd,
    output logic            busy
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CMP   = 4'b0010,
        ST_INS   = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (action == ACT_EXECUTE) ? ST_DRAIN : ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = ST_INS;
            end
            ST_INS:
            begin
                // insert lands on this edge; a new item may be taken with it
                busy       = 1'b0;
                cmd.insert = 1'b1;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (action == ACT_EXECUTE) ? ST_DRAIN : ST_CMP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (dp_status.cnt_zero)
                begin
                    cmd.drain_end = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.drain_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/sptq_datapath.sv]
// ----------------------------------------------------------------------------
// sptq_datapath
// Sorted shift-register queue, insert compare, drain shift, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sptq_datapath
    import sptq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire request_t   request,
    input  wire ctrl_cmd_t  cmd,
    output dp_status_t      dp_status,
    output result_t         result,
    output logic            result_valid
);

    // latched item
    logic                    present_reg;
    logic [TAG_BITS-1:0]     tag_reg;
    logic [PRIO_W-1:0]       prio_reg;

    // queue cells, entry 0 is the head
    logic [TAG_BITS-1:0]     cell_tag_reg  [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]     cell_tag_next [QUEUE_DEPTH];
    logic [PRIO_W-1:0]       cell_prio_reg [QUEUE_DEPTH];
    logic [PRIO_W-1:0]       cell_prio_next[QUEUE_DEPTH];
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CNT_W-1:0]        drain_idx_reg;

    // compare stage
    logic [QUEUE_DEPTH-1:0]  le_vec;
    logic [QUEUE_DEPTH-1:0]  gt_vec;
    logic [QUEUE_DEPTH-1:0]  gt_reg;
    logic [QUEUE_DEPTH-1:0]  gt_prev;
    logic [QUEUE_DEPTH-1:0]  at_cnt;
    logic [GRP_CNT_W-1:0]    grp_cnt_next[NUM_GRP];
    logic [GRP_CNT_W-1:0]    grp_cnt_reg [NUM_GRP];
    logic [CNT_W-1:0]        ins_pos;

    logic                    is_full;
    logic                    ins_ok;
    result_t                 res_next;
    logic                    res_valid_next;
    result_t                 res_reg;
    logic                    res_valid_reg;

    assign is_full          = (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign ins_ok           = present_reg && !is_full;
    assign dp_status.cnt_zero = (count_reg == '0);
    assign gt_prev          = {gt_reg[QUEUE_DEPTH-2:0], 1'b0};

    // per-cell compare against the new priority
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            le_vec[i] = (CNT_W'(i) < count_reg) && (cell_prio_reg[i] <= prio_reg);
            gt_vec[i] = (CNT_W'(i) < count_reg) && (cell_prio_reg[i] > prio_reg);
            at_cnt[i] = (count_reg == CNT_W'(i));
        end
    end

    // partial counts of entries that stay ahead of the new one
    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_cnt_next[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++)
            begin
                if (g * GRP_SIZE + j < QUEUE_DEPTH)
                begin
                    grp_cnt_next[g] = grp_cnt_next[g]
                                    + GRP_CNT_W'(le_vec[g * GRP_SIZE + j]);
                end
            end
        end
    end

    always_comb
    begin
        ins_pos = '0;
        for (int g = 0; g < NUM_GRP; g++)
        begin
            ins_pos = ins_pos + CNT_W'(grp_cnt_reg[g]);
        end
    end

    // cell updates: insert opens a slot, drain pops the head
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            cell_tag_next[i]  = cell_tag_reg[i];
            cell_prio_next[i] = cell_prio_reg[i];
        end
        if (cmd.insert && ins_ok)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                if (gt_prev[i])
                begin
                    cell_tag_next[i]  = cell_tag_reg[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                    cell_prio_next[i] = cell_prio_reg[(i + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                end
                else if (gt_reg[i] || at_cnt[i])
                begin
                    cell_tag_next[i]  = tag_reg;
                    cell_prio_next[i] = prio_reg;
                end
            end
        end
        else if (cmd.drain_step)
        begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
            begin
                cell_tag_next[i]  = cell_tag_reg[i + 1];
                cell_prio_next[i] = cell_prio_reg[i + 1];
            end
        end
    end

    // result and count
    always_comb
    begin
        res_next       = res_reg;
        res_valid_next = 1'b0;
        count_next     = count_reg;
        if (cmd.insert)
        begin
            res_valid_next         = 1'b1;
            res_next               = '0;
            res_next.kind          = KIND_SCHED;
            res_next.last          = 1'b1;
            res_next.pending_count = PEND_W'(count_reg);
            if (!present_reg)
            begin
                res_next.status = STS_NO_NAME;
            end
            else if (is_full)
            begin
                res_next.status = STS_FULL;
            end
            else
            begin
                res_next.status        = STS_OK;
                res_next.position      = POS_W'(ins_pos);
                count_next             = count_reg + 1'b1;
                res_next.pending_count = PEND_W'(count_next);
            end
        end
        else if (cmd.drain_step)
        begin
            res_valid_next         = 1'b1;
            count_next             = count_reg - 1'b1;
            res_next.kind          = KIND_TASK;
            res_next.status        = STS_OK;
            res_next.position      = POS_W'(drain_idx_reg);
            res_next.out_tag       = OUT_TAG_W'(cell_tag_reg[0]);
            res_next.out_priority  = cell_prio_reg[0];
            res_next.drain_ok      = 1'b0;
            res_next.pending_count = PEND_W'(count_next);
            res_next.last          = 1'b0;
        end
        else if (cmd.drain_end)
        begin
            res_valid_next    = 1'b1;
            count_next        = '0;
            res_next          = '0;
            res_next.kind     = KIND_DONE;
            res_next.status   = STS_OK;
            res_next.drain_ok = 1'b1;
            res_next.last     = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drain_idx_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            if (cmd.load)
            begin
                drain_idx_reg <= '0;
            end
            else if (cmd.drain_step)
            begin
                drain_idx_reg <= drain_idx_reg + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            present_reg <= request.name_present;
            tag_reg     <= TAG_BITS'(request.task_tag);
            prio_reg    <= clamp_prio(request.priority_req);
        end
        if (cmd.compare)
        begin
            gt_reg      <= gt_vec;
            grp_cnt_reg <= grp_cnt_next;
        end
        cell_tag_reg  <= cell_tag_next;
        cell_prio_reg <= cell_prio_next;
        res_reg       <= res_next;
    end

    assign result       = res_reg;
    assign result_valid = res_valid_reg;

endmodule

`default_nettype wire

[rtl/sorted_priority_task_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_task_queue
// Priority-ordered task queue with insert-by-shift and full drain.
//
//  channel   | ports                        | handshake
//  ----------+------------------------------+-------------------------------
//  item in   | start, busy, request         | taken when start && !busy
//  result    | result_valid, result         | one-cycle strobe, no stall
//
//  Schedule: accept, compare, insert; the result is registered at the
//  insert edge, and a new item may be taken at that same edge.
//  Execute: one result per cycle for each queued task, then the done
//  result; busy stays high until the done result is issued.
//  The controller sequence and the compare/shift cells set these steps.
//  Reset clears the fill count, the sequencer and the result strobe; the
//  queue cells are not cleared and are never read beyond the fill count.
//  The receiver cannot stall: every result is on the ports for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_task_queue
    import sptq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t request,
    output logic          result_valid,
    output result_t       result
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    // sequencer: decides compare, insert and drain steps
    sptq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (request.action),
        .dp_status (dp_status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // queue cells, compare logic and result register
    sptq_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .dp_status    (dp_status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire

[rtl/sptq_checker.sv]
// ----------------------------------------------------------------------------
// sptq_checker
// Port-level assertions for the sorted priority task queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_priority_task_queue_assert.svh"

module sptq_checker
    import sptq_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire request_t request,
    input wire logic     result_valid,
    input wire result_t  result
);

    logic sched_take;
    logic done_seen;
    logic done_good;
    logic task_seen;
    logic refuse_seen;
    logic refuse_good;

    assign sched_take  = start && !busy && (request.action == ACT_SCHEDULE);
    assign done_seen   = result_valid && (result.kind == KIND_DONE);
    assign done_good   = result.last && result.drain_ok && (result.pending_count == '0);
    assign task_seen   = result_valid && (result.kind == KIND_TASK);
    assign refuse_seen = result_valid && (result.status != STS_OK);
    assign refuse_good = (result.kind == KIND_SCHED) && (result.position == '0);

    // a schedule item always needs its compare cycle
    `SPTQ_ASSERT_NXT(a_sched_busy, clk, rst_n, sched_take, busy)

    // done result closes the drain with an empty queue
    `SPTQ_ASSERT_IMP(a_done_fields, clk, rst_n, done_seen, done_good)

    // drained tasks appear only while the drain is still running
    `SPTQ_ASSERT_IMP(a_task_busy, clk, rst_n, task_seen, busy && !result.last)

    // refusals are schedule answers at position zero
    `SPTQ_ASSERT_IMP(a_refuse, clk, rst_n, refuse_seen, refuse_good)

endmodule

bind sorted_priority_task_queue sptq_checker u_sptq_checker (.*);

`default_nettype wire

[test/sorted_priority_task_queue_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_task_queue_test
// Self-checking bench for the sorted priority task queue. A shadow copy of
// the queue predicts each schedule answer and each drain result, and a
// monitor compares every strobed result with the oldest prediction. The
// stimulus is a short directed run followed by random fill/drain bursts.
// ----------------------------------------------------------------------------

module sorted_priority_task_queue_test;
    import sptq_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 230;
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned DRAIN_SETTLE = 8;

    // Sender idle percentage per burst phase: none, heavy, none (the result
    // side cannot stall, so that phase runs flat out), light.
    localparam int unsigned IDLE_BY_PHASE [4] = '{0, 82, 0, 13};

    // Priority corner values: most negative, -1, 0, top of range, just
    // above it, most positive.
    localparam logic [REQ_W-1:0] PRIO_EDGES [6] =
        '{16'h8000, 16'hFFFF, 16'h0000, 16'd100, 16'd101, 16'h7FFF};

    // ------------------------------------------------------------------------
    // Scoreboard: shadow queue plus the FIFO of predicted results.
    // ------------------------------------------------------------------------
    class queue_scoreboard;
        logic [IN_TAG_W-1:0] tags  [QUEUE_DEPTH];
        logic [PRIO_W-1:0]   prios [QUEUE_DEPTH];
        int                  fill;
        result_t             pending_results [$];

        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned schedules;
        int unsigned refusals;
        int unsigned drains;
        int unsigned drained_tasks;
        int          peak_fill;

        function new();
            fill          = 0;
            mismatches    = 0;
            results_seen  = 0;
            schedules     = 0;
            refusals      = 0;
            drains        = 0;
            drained_tasks = 0;
            peak_fill     = 0;
        endfunction

        // Accepted item: update the shadow queue, queue up its results.
        function void note_request(request_t req);
            result_t           want;
            int                slot;
            int                req_val;
            logic [PRIO_W-1:0] prio;
            want = '0;
            if (req.action == ACT_SCHEDULE)
            begin
                schedules++;
                want.kind = KIND_SCHED;
                want.last = 1'b1;
                // missing name is reported even when the queue is also full
                if (!req.name_present)
                begin
                    want.status = STS_NO_NAME;
                    refusals++;
                end
                else if (fill >= QUEUE_DEPTH)
                begin
                    want.status = STS_FULL;
                    refusals++;
                end
                else
                begin
                    req_val = $signed(req.priority_req);
                    if (req_val < 0)
                        prio = '0;
                    else if (req_val > PRIO_MAX)
                        prio = PRIO_W'(PRIO_MAX);
                    else
                        prio = PRIO_W'(req_val);
                    // first entry with a strictly larger priority; ties stay behind
                    slot = fill;
                    for (int i = fill - 1; i >= 0; i--)
                        if (prios[i] > prio)
                            slot = i;
                    for (int i = fill; i > slot; i--)
                    begin
                        tags[i]  = tags[i-1];
                        prios[i] = prios[i-1];
                    end
                    tags[slot]  = req.task_tag;
                    prios[slot] = prio;
                    fill++;
                    if (fill > peak_fill)
                        peak_fill = fill;
                    want.status   = STS_OK;
                    want.position = POS_W'(slot);
                end
                want.pending_count = PEND_W'(fill);
                pending_results.push_back(want);
            end
            else
            begin
                drains++;
                for (int i = 0; i < fill; i++)
                begin
                    want               = '0;
                    want.kind          = KIND_TASK;
                    want.status        = STS_OK;
                    want.position      = POS_W'(i);
                    want.out_tag       = OUT_TAG_W'(tags[i]);
                    want.out_priority  = prios[i];
                    want.pending_count = PEND_W'(fill - i - 1);
                    pending_results.push_back(want);
                    drained_tasks++;
                end
                fill          = 0;
                want          = '0;
                want.kind     = KIND_DONE;
                want.status   = STS_OK;
                want.drain_ok = 1'b1;
                want.last     = 1'b1;
                pending_results.push_back(want);
            end
        endfunction

        // Strobed result: compare with the oldest prediction.
        function void check_result(result_t got);
            result_t want;
            logic    bad;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                if (mismatches < REPORT_MAX)
                    $display("unexpected result %0d: kind=%0d sts=%0d pos=%0d tag=%h",
                             results_seen, got.kind, got.status, got.position, got.out_tag);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            bad = (got.kind != want.kind) || (got.status != want.status) ||
                  (got.position != want.position) || (got.out_tag != want.out_tag) ||
                  (got.out_priority != want.out_priority) ||
                  (got.drain_ok != want.drain_ok) ||
                  (got.pending_count != want.pending_count) || (got.last != want.last);
            if (bad)
            begin
                if (mismatches < REPORT_MAX)
                begin
                    $display("mismatch at result %0d:", results_seen);
                    $display("  expected kind=%0d sts=%0d pos=%0d tag=%h prio=%0d ok=%b pend=%0d last=%b",
                             want.kind, want.status, want.position, want.out_tag,
                             want.out_priority, want.drain_ok, want.pending_count,
                             want.last);
                    $display("  actual   kind=%0d sts=%0d pos=%0d tag=%h prio=%0d ok=%b pend=%0d last=%b",
                             got.kind, got.status, got.position, got.out_tag,
                             got.out_priority, got.drain_ok, got.pending_count,
                             got.last);
                end
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals; inputs are known from time zero.
    // ------------------------------------------------------------------------
    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    request_t    request = '0;
    logic        result_valid;
    result_t     result;

    queue_scoreboard board;
    int unsigned     cycles = 0;

    sorted_priority_task_queue i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: the slowest legal run is far below this.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, board.pending_results.size());
            $display("sorted_priority_task_queue_test: done, errors");
            $finish;
        end
    end

    // Monitor. Everything is sampled at the rising edge, before the NBAs of
    // that edge land, so driver and DUT updates cannot race the check.
    // Results from this edge belong to earlier items, so check first.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
                board.check_result(result);
            if (start && !busy)
                board.note_request(request);
        end
    end

    function automatic request_t make_item(logic act, logic present,
                                           logic [IN_TAG_W-1:0] tag,
                                           logic [REQ_W-1:0] prio_raw);
        request_t item;
        item.action       = act;
        item.name_present = present;
        item.task_tag     = tag;
        item.priority_req = prio_raw;
        return item;
    endfunction

    // Present one item and hold it until the DUT takes it. Called at a rising
    // edge; returns at the edge that accepted the item. Random idle cycles
    // come first, with junk on the request bus while start is low.
    task automatic send_item(input request_t item, input int unsigned idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start   <= 1'b0;
            request <= make_item(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        start   <= 1'b1;
        request <= item;
        do
            @(posedge clk);
        while (busy);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        request_t          directed_items [$];
        request_t          item;
        int unsigned       sent;
        int unsigned       burst;
        int unsigned       burst_len;
        int unsigned       idle_pct;
        logic              present;
        logic [REQ_W-1:0]  prio_raw;

        board = new();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: drain of an empty queue, refusals, clamping at both ends,
        // tie ordering, extreme tags, then drain and drain again when empty.
        directed_items.push_back(make_item(ACT_EXECUTE,  1'b0, 16'hAAAA, 16'h5555));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b0, 16'hFFFF, 16'h7FFF));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b1, 16'h0000, 16'h8000));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b1, 16'hFFFF, 16'h7FFF));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b1, 16'h1234, 16'd100));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b1, 16'h5678, 16'd101));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b1, 16'h0001, 16'hFFFF));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b1, 16'h8000, 16'd0));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b1, 16'h00FF, 16'd50));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b1, 16'hFF00, 16'd1));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b0, 16'h4321, 16'd50));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b1, 16'h7FFF, 16'd99));
        directed_items.push_back(make_item(ACT_EXECUTE,  1'b1, 16'h5555, 16'hAAAA));
        directed_items.push_back(make_item(ACT_EXECUTE,  1'b0, 16'h0000, 16'h0000));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b1, 16'hBEEF, 16'd99));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b1, 16'hC0DE, 16'd7));
        directed_items.push_back(make_item(ACT_SCHEDULE, 1'b1, 16'h0F0F, 16'd7));
        directed_items.push_back(make_item(ACT_EXECUTE,  1'b1, 16'hFFFF, 16'hFFFF));
        foreach (directed_items[k])
            send_item(directed_items[k], 0);

        // Random bursts: a run of schedules then a drain. Burst 0 fills the
        // queue exactly, hits it once when full and once full with no name.
        // Later bursts are mostly short, sometimes long enough to overflow,
        // with the odd stray drain and missing name mixed in.
        sent  = 0;
        burst = 0;
        while (sent < RANDOM_ITEMS)
        begin
            idle_pct = IDLE_BY_PHASE[burst % 4];
            if (burst == 0)
                burst_len = QUEUE_DEPTH + 2;
            else if ($urandom_range(0, 3) == 0)
                burst_len = $urandom_range(QUEUE_DEPTH, QUEUE_DEPTH + 6);
            else
                burst_len = $urandom_range(0, 12);

            for (int j = 0; j < burst_len; j++)
            begin
                case ($urandom_range(0, 3))
                    0:       prio_raw = 16'($urandom);
                    1:       prio_raw = 16'($urandom_range(0, PRIO_MAX));
                    2:       prio_raw = 16'($urandom_range(0, 7));   // many ties
                    default: prio_raw = PRIO_EDGES[$urandom_range(0, 5)];
                endcase
                if (burst == 0)
                    present = (j != QUEUE_DEPTH + 1);
                else
                    present = ($urandom_range(0, 9) != 0);

                if (burst != 0 && $urandom_range(0, 15) == 0)
                    item = make_item(ACT_EXECUTE, present, 16'($urandom), prio_raw);
                else
                    item = make_item(ACT_SCHEDULE, present, 16'($urandom), prio_raw);
                send_item(item, idle_pct);
                sent++;
            end

            send_item(make_item(ACT_EXECUTE, 1'($urandom), 16'($urandom), 16'($urandom)),
                      idle_pct);
            sent++;
            burst++;
        end
        start <= 1'b0;

        // Let the last drain finish, then wait out the settle period for strays.
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);

        $display("covered %0d schedules (%0d refused, peak fill %0d of %0d),",
                 board.schedules, board.refusals, board.peak_fill, QUEUE_DEPTH);
        $display("  %0d drains of %0d tasks, %0d results compared over %0d bursts, %0d mismatches",
                 board.drains, board.drained_tasks, board.results_seen, burst,
                 board.mismatches);
        if (board.mismatches == 0 && board.pending_results.size() == 0)
            $display("sorted_priority_task_queue_test: done, clean");
        else
            $display("sorted_priority_task_queue_test: done, errors");
        $finish;
    end

endmodule
